>>> design/svad_pkg.sv
// Shared constants and types for the supply voltage averager.
package svad_pkg;

  // Field widths
  localparam int unsigned PIN_W      = 12;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned AVG_W      = 16;
  localparam int unsigned SCALED_W   = 18;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned SCALE_FRAC = 14;

  // Supply divider ratio and largest supply sample (4095 * 11)
  localparam int unsigned SUPPLY_DIVIDER = 11;
  localparam int unsigned SAMPLE_MAX     = 45045;

  localparam int unsigned FILTER_DEPTH_DEFAULT = 16;

  // Voltage band edge in supply mV
  localparam logic [AVG_W-1:0] UPPER_BAND_MV = AVG_W'(18000);

  // Register reset values
  localparam logic [CFG_W-1:0] THRESHOLD_RESET = CFG_W'(13000);
  localparam logic [CFG_W-1:0] SCALE_RESET     = CFG_W'(16384);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_SCALE     = 1'b1
  } cfg_reg_e;

endpackage

>>> design/supply_voltage_average_ignition_detect_core.sv
// Top level: supply voltage moving average with calibration gain and ignition flag.
//
//  channel   dir  handshake                    payload (lowest bit first)
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: pin_mv[11:0], zero pad to 16
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: average_supply_mv[15:0],
//                                              scaled_supply_mv[33:16],
//                                              engine_running[34], reading_valid[35],
//                                              zero pad to 40
//  cfg       in   cfg_we_i                     cfg_idx_i, cfg_data_i[15:0]
//
// Steps: each request goes from acceptance through the sum update, the bit-serial
//   divide by the fill count, the hand-on of the quotient to the multiplier, the
//   bit-serial gain multiply and the load into the result register.
// One request is in flight at a time; s_axis_tready is high only when idle.
// The output register lets a new request be taken while the last result waits.
// A stalled result only holds the pipeline at its final load step.
// Reset clears pointers, sum and fill state and restores the configuration registers; the sample store is not cleared.
module supply_voltage_average_ignition_detect_core #(
  parameter int unsigned FILTER_DEPTH = svad_pkg::FILTER_DEPTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input samples
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // pin_mv[11:0]
  // results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [39:0]                     m_axis_tdata,   // avg, scaled, flag, valid
  // configuration
  input  logic                            cfg_we_i,
  input  logic [svad_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [svad_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned SUM_W = $clog2(FILTER_DEPTH * svad_pkg::SAMPLE_MAX + 1);
  localparam int unsigned CNT_W = $clog2(FILTER_DEPTH + 1);
  localparam int unsigned AVG_W = svad_pkg::AVG_W;
  localparam int unsigned PROD_W = AVG_W + svad_pkg::CFG_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [svad_pkg::CFG_W-1:0] thr_q, scale_q;
  logic                       accept;
  logic [SUM_W-1:0]           sum_next;
  logic [CNT_W-1:0]           count;
  logic                       div_start, div_busy, div_done;
  logic [SUM_W-1:0]           quotient;
  logic                       mul_start, mul_busy, mul_done;
  logic [PROD_W-1:0]          product;
  logic [AVG_W-1:0]           avg_q;
  logic                       load_out;
  logic                       flag;
  logic [AVG_W:0]             thr2;

  logic                       m_valid_q;
  logic [AVG_W-1:0]           out_avg_q;
  logic [svad_pkg::SCALED_W-1:0] out_scaled_q;
  logic                       out_flag_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= svad_pkg::THRESHOLD_RESET;
      scale_q <= svad_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      case (svad_pkg::cfg_reg_e'(cfg_idx_i))
        svad_pkg::REG_THRESHOLD: thr_q   <= cfg_data_i;
        svad_pkg::REG_SCALE:     scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  svad_ring #(
    .FILTER_DEPTH (FILTER_DEPTH),
    .SUM_W        (SUM_W),
    .CNT_W        (CNT_W)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (accept),
    .pin_mv_i   (s_axis_tdata[svad_pkg::PIN_W-1:0]),
    .upd_i      (state_q == ST_SUM),
    .sum_next_o (sum_next),
    .count_o    (count)
  );

  // divider loads the updated sum in the same cycle it is committed
  assign div_start = (state_q == ST_SUM);

  svad_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_next),
    .divisor_i  (count),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign mul_start = (state_q == ST_DIV) && div_done;

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      avg_q <= quotient[AVG_W-1:0];
    end
  end

  svad_mult #(
    .A_W (AVG_W),
    .B_W (svad_pkg::CFG_W)
  ) u_mult (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (quotient[AVG_W-1:0]),
    .b_i       (scale_q),
    .busy_o    (mul_busy),
    .done_o    (mul_done),
    .product_o (product)
  );

  // voltage bands: off below thr, running below 18 V, off below 2*thr, else running
  assign thr2 = {thr_q, 1'b0};
  always_comb begin
    if (avg_q < thr_q) begin
      flag = 1'b0;
    end else if (avg_q < svad_pkg::UPPER_BAND_MV) begin
      flag = 1'b1;
    end else if ({1'b0, avg_q} < thr2) begin
      flag = 1'b0;
    end else begin
      flag = 1'b1;
    end
  end

  assign load_out = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept)    state_d = ST_SUM;
      ST_SUM:                 state_d = ST_DIV;
      ST_DIV:  if (div_done)  state_d = ST_MUL;
      ST_MUL:  if (mul_done)  state_d = ST_OUT;
      ST_OUT:  if (load_out)  state_d = ST_IDLE;
      default:                state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_avg_q    <= avg_q;
      out_scaled_q <= product[svad_pkg::SCALE_FRAC + svad_pkg::SCALED_W - 1 :
                              svad_pkg::SCALE_FRAC];
      out_flag_q   <= flag;
    end
  end

  // a sample is always held once a result exists, so reading_valid is set
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, 1'b1, out_flag_q, out_scaled_q, out_avg_q};

  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_busy && !mul_busy)
    else $error("input ready while an arithmetic unit is busy");

  a_div_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |=> state_q == ST_MUL && mul_busy)
    else $error("multiply did not follow divide");

  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] <= 16'(svad_pkg::SAMPLE_MAX))
    else $error("average above largest supply sample");

endmodule

>>> design/svad_ring.sv
// Sample ring with running sum and fill count.
module svad_ring #(
  parameter int unsigned FILTER_DEPTH = svad_pkg::FILTER_DEPTH_DEFAULT,
  parameter int unsigned SUM_W        = 20,
  parameter int unsigned CNT_W        = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [svad_pkg::PIN_W-1:0]    pin_mv_i,
  input  logic                          upd_i,
  output logic [SUM_W-1:0]              sum_next_o,
  output logic [CNT_W-1:0]              count_o
);

  localparam int unsigned PTR_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;

  logic [svad_pkg::SAMPLE_W-1:0] mem [FILTER_DEPTH];
  logic [svad_pkg::SAMPLE_W-1:0] sample;
  logic [svad_pkg::SAMPLE_W-1:0] sample_q;
  logic [svad_pkg::SAMPLE_W-1:0] old_q;
  logic [PTR_W-1:0]              pos_q, pos_d;
  logic                          full_q, full_d;
  logic                          sub_q;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [SUM_W-1:0]              sum_q, sum_d;
  logic                          wrap;

  assign sample = svad_pkg::SAMPLE_W'(pin_mv_i) *
                  svad_pkg::SAMPLE_W'(svad_pkg::SUPPLY_DIVIDER);

  assign wrap    = (pos_q == PTR_W'(FILTER_DEPTH - 1));
  assign pos_d   = wrap ? '0 : pos_q + PTR_W'(1);
  assign full_d  = full_q | wrap;
  assign count_d = full_d ? CNT_W'(FILTER_DEPTH) : CNT_W'(pos_q) + CNT_W'(1);

  // old entry only leaves the sum once the ring has wrapped
  assign sum_d = sum_q + SUM_W'(sample_q) - (sub_q ? SUM_W'(old_q) : '0);

  // storage: write new sample, read the entry it replaces
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[pos_q] <= sample;
      old_q      <= mem[pos_q];
      sample_q   <= sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      full_q  <= 1'b0;
      sub_q   <= 1'b0;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      if (we_i) begin
        pos_q   <= pos_d;
        full_q  <= full_d;
        sub_q   <= full_q;
        count_q <= count_d;
      end
      if (upd_i) begin
        sum_q <= sum_d;
      end
    end
  end

  assign sum_next_o = sum_d;
  assign count_o    = count_q;

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_i |=> count_q != '0)
    else $error("fill count zero after a sample was stored");

endmodule

>>> design/svad_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module svad_div #(
  parameter int unsigned DIVIDEND_W = 20,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned ITER_W = $clog2(DIVIDEND_W);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  divisor_q;
  logic [ITER_W-1:0]     iter_q;
  logic                  busy_q, done_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign ge    = (trial >= {1'b0, divisor_q});
  assign rem_d = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  assign quo_d = {quo_q[DIVIDEND_W-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !$past(start_i) |-> rem_q < divisor_q)
    else $error("partial remainder not below divisor");

endmodule

>>> design/svad_mult.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module svad_mult #(
  parameter int unsigned A_W = 16,
  parameter int unsigned B_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [A_W-1:0]   a_i,
  input  logic [B_W-1:0]   b_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [A_W+B_W-1:0] product_o
);

  localparam int unsigned ITER_W = (B_W > 1) ? $clog2(B_W) : 1;

  logic [A_W-1:0]   a_q;
  logic [A_W-1:0]   hi_q;
  logic [B_W-1:0]   lo_q;
  logic [A_W:0]     psum;
  logic [ITER_W-1:0] iter_q;
  logic             busy_q, done_q;

  assign psum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= psum[A_W:1];
      lo_q <= {psum[0], lo_q[B_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o    = busy_q;
  assign done_o    = done_q;
  assign product_o = {hi_q, lo_q};

endmodule

>>> bench/supply_voltage_average_ignition_detect_core_tb.sv
// Self-checking bench for the supply voltage averager: directed script, random phases, scoreboard.
module supply_voltage_average_ignition_detect_core_tb;
  import svad_pkg::*;

  localparam int unsigned DEPTH          = FILTER_DEPTH_DEFAULT;
  localparam int unsigned ITEMS_PER_RUN  = 75;    // six random phases, ~450 requests
  localparam int unsigned SQUEEZE_CYCLES = 400;   // long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int unsigned TAIL_CYCLES    = 130;   // idle tail after the queue drains

  // One result, lowest tdata bits last in the packed order
  typedef struct packed {
    logic                reading_ok;
    logic                engine_on;
    logic [SCALED_W-1:0] scaled_mv;
    logic [AVG_W-1:0]    avg_mv;
  } supply_reading_t;

  // Directed script row: tdata word, and a hand-worked result where one is given
  typedef struct packed {
    logic [15:0]     word;
    logic            typed;
    supply_reading_t want;
  } pin_row_t;

  // Reset settings (threshold 13000, gain 1.0). The first four rows are worked by hand:
  // full scale, then zeros, with pad bits set on the third to show they are ignored.
  // Later rows straddle the band edges and run the ring past its wrap.
  localparam pin_row_t PIN_SCRIPT [20] = '{
    '{16'h0FFF, 1'b1, '{1'b1, 1'b1, 18'd45045, 16'd45045}},
    '{16'h0000, 1'b1, '{1'b1, 1'b0, 18'd22522, 16'd22522}},
    '{16'hF000, 1'b1, '{1'b1, 1'b1, 18'd15015, 16'd15015}},
    '{16'h0000, 1'b1, '{1'b1, 1'b0, 18'd11261, 16'd11261}},
    '{16'h0001, 1'b0, '0},
    '{16'h0AAA, 1'b0, '0},
    '{16'h0555, 1'b0, '0},
    '{16'hFFFF, 1'b0, '0},
    '{16'h0800, 1'b0, '0},
    '{16'h07FF, 1'b0, '0},
    '{16'h049D, 1'b0, '0},   // just under the threshold once scaled
    '{16'h049E, 1'b0, '0},   // just over
    '{16'h0664, 1'b0, '0},   // just under the 18 V edge
    '{16'h0665, 1'b0, '0},   // just over
    '{16'h0FFF, 1'b0, '0},
    '{16'h0FFF, 1'b0, '0},   // sixteenth sample: ring wraps here
    '{16'h0000, 1'b0, '0},   // overwrites the first full-scale entry
    '{16'h0FFF, 1'b0, '0},
    '{16'h8123, 1'b0, '0},
    '{16'h0000, 1'b0, '0}
  };

  // DUT ports, all inputs known from time zero
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = REG_THRESHOLD;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  // Traffic knobs
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;
  bit          squeeze_arm   = 1'b0;
  bit          squeeze_done  = 1'b0;
  int unsigned squeeze_left  = 0;

  // Predictor state: own copy of the ring, the sum and both registers
  logic [SAMPLE_W-1:0] ring_q [DEPTH];
  int unsigned         wr_pos_q;
  bit                  ring_full_q;
  int unsigned         sum_q;
  logic [CFG_W-1:0]    thr_q;
  logic [CFG_W-1:0]    scale_q;

  // Random level generator: holds a level for a while so the mean settles near it
  int                  level_pin;
  int unsigned         level_left = 0;

  supply_reading_t     expected_readings [$];
  int unsigned         mismatches = 0;
  int unsigned         results_seen = 0;

  supply_voltage_average_ignition_detect_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // pin_mv[11:0], pad[15:12]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // avg[15:0], scaled[33:16], running[34], valid[35]
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Steps the ring model by one sample and returns the reading it should give
  function automatic supply_reading_t predict_reading(input logic [15:0] word);
    logic [SAMPLE_W-1:0] sample;
    int unsigned         count;
    int unsigned         avg;
    longint unsigned     prod;
    supply_reading_t     r;
    sample = SAMPLE_W'(word[PIN_W-1:0]) * SAMPLE_W'(SUPPLY_DIVIDER);
    if (ring_full_q) sum_q -= ring_q[wr_pos_q];
    ring_q[wr_pos_q] = sample;
    sum_q += sample;
    wr_pos_q = (wr_pos_q == DEPTH - 1) ? 0 : wr_pos_q + 1;
    if (wr_pos_q == 0) ring_full_q = 1'b1;
    count = ring_full_q ? DEPTH : wr_pos_q;
    avg   = sum_q / count;
    prod  = avg;
    prod  = prod * scale_q;
    r.avg_mv     = AVG_W'(avg);
    r.scaled_mv  = SCALED_W'(prod >> SCALE_FRAC);
    // bands: off, running, overcharge-off, running again above twice the threshold
    if (avg < thr_q)                    r.engine_on = 1'b0;
    else if (avg < UPPER_BAND_MV)       r.engine_on = 1'b1;
    else if (avg < (32'(thr_q) << 1))   r.engine_on = 1'b0;
    else                                r.engine_on = 1'b1;
    r.reading_ok = 1'b1;
    return r;
  endfunction

  // Next random tdata word: mostly near a held level, sometimes anywhere, rare pad bits
  function automatic logic [15:0] next_pin_word();
    int          p;
    logic [15:0] word;
    if (level_left == 0) begin
      level_left = $urandom_range(8, 40);
      case ($urandom_range(0, 6))
        0:       level_pin = thr_q / SUPPLY_DIVIDER;
        1:       level_pin = UPPER_BAND_MV / SUPPLY_DIVIDER;
        2:       level_pin = (32'(thr_q) << 1) / SUPPLY_DIVIDER;
        3:       level_pin = 0;
        4:       level_pin = 4095;
        default: level_pin = $urandom_range(0, 4095);
      endcase
    end
    level_left--;
    if ($urandom_range(0, 4) == 0) p = $urandom_range(0, 4095);
    else                           p = level_pin + int'($urandom_range(0, 24)) - 12;
    if (p < 0)    p = 0;
    if (p > 4095) p = 4095;
    word = {4'b0000, 12'(p)};
    if ($urandom_range(0, 15) == 0) word[15:12] = 4'($urandom_range(1, 15));
    return word;
  endfunction

  // Offers one request, waits for the handshake, then queues what should come back
  task automatic feed_pin(input logic [15:0] word, input logic typed,
                          input supply_reading_t want);
    supply_reading_t r;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_reading(word);
    expected_readings.push_back(typed ? want : r);
  endtask

  // Back-to-back writes of both registers; the block is idle when this is called
  task automatic load_settings(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] scale);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_THRESHOLD;
    cfg_data_i <= thr;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SCALE;
    cfg_data_i <= scale;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    thr_q   = thr;
    scale_q = scale;
  endtask

  // Drain, reprogram, then stream random requests under the given traffic
  task automatic run_phase(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] scale,
                           input int unsigned snd, input int unsigned rcv,
                           input bit squeeze);
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    load_settings(thr, scale);
    snd_idle_pct   = snd;
    rcv_stall_pct <= rcv;
    if (squeeze) squeeze_arm <= 1'b1;
    repeat (ITEMS_PER_RUN) feed_pin(next_pin_word(), 1'b0, '0);
  endtask

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on result %0d: %s got %0d expected %0d",
             results_seen, field, got, want);
    mismatches++;
  endtask

  // Receiver: random stalls, plus one long hold-off so the output register
  // fills, the core backs up and s_axis_tready drops while requests keep coming
  always @(posedge clk_i) begin
    if (squeeze_left != 0) begin
      m_axis_tready <= 1'b0;
      squeeze_left  <= squeeze_left - 1;
    end else if (squeeze_arm && !squeeze_done) begin
      m_axis_tready <= 1'b0;
      squeeze_left  <= SQUEEZE_CYCLES;
      squeeze_done  <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // Scoreboard: each accepted result against the oldest expectation
  always @(posedge clk_i) begin : result_check
    supply_reading_t got;
    supply_reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = supply_reading_t'(m_axis_tdata[35:0]);
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result, avg", got.avg_mv, 0);
      end else begin
        want = expected_readings.pop_front();
        if (got.avg_mv !== want.avg_mv)
          report_mismatch("average_supply_mv", got.avg_mv, want.avg_mv);
        if (got.scaled_mv !== want.scaled_mv)
          report_mismatch("scaled_supply_mv", got.scaled_mv, want.scaled_mv);
        if (got.engine_on !== want.engine_on)
          report_mismatch("engine_running", got.engine_on, want.engine_on);
        if (got.reading_ok !== want.reading_ok)
          report_mismatch("reading_valid", got.reading_ok, want.reading_ok);
      end
      results_seen++;
    end
  end

  // Watchdog: too long with no request moving on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wr_pos_q    = 0;
    ring_full_q = 1'b0;
    sum_q       = 0;
    thr_q       = THRESHOLD_RESET;
    scale_q     = SCALE_RESET;
    @(posedge clk_i);

    // directed script at reset settings, no idling
    foreach (PIN_SCRIPT[i]) feed_pin(PIN_SCRIPT[i].word, PIN_SCRIPT[i].typed, PIN_SCRIPT[i].want);

    // threshold 0: flag always set; full gain
    run_phase(16'd0, 16'hFFFF, 0, 0, 1'b0);
    // threshold at the largest supply sample, gain 0, sparse sender
    run_phase(CFG_W'(SAMPLE_MAX), 16'd0, 84, 0, 1'b0);
    // twice the threshold lands on the 18 V edge; slow receiver
    run_phase(16'd9000, SCALE_RESET, 0, 84, 1'b0);
    // random settings, light idling both sides
    run_phase(CFG_W'($urandom_range(0, SAMPLE_MAX)), CFG_W'($urandom_range(0, 65535)),
              13, 13, 1'b0);
    // back-pressure phase: sender flat out, receiver holds off once
    run_phase(THRESHOLD_RESET, 16'd1, 0, 0, 1'b1);
    // threshold in 9001..18000: all four flag regions exist except at 18000
    run_phase(CFG_W'($urandom_range(9001, 18000)), CFG_W'($urandom_range(0, 65535)),
              13, 13, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
